// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman bit decoder package
// Shared constants, request codes and the node table entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbd_pkg;

   // Node table depth and the width of a table address.
   localparam int NODES     = 512;
   localparam int NODE_BITS = $clog2(NODES);

   // Width of node indices as they travel in requests and registers.
   localparam int IDX_W = 9;

   // Width of the decoded symbol counter.
   localparam int COUNT_BITS = 32;

   // Bits in one data byte and the width of the bit position counter.
   localparam int BYTE_BITS = 8;
   localparam int BIT_W     = $clog2(BYTE_BITS);

   // Request kinds carried in the request tuser field.
   localparam logic [1:0] KIND_NODE  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TOTAL_SYMBOLS = 1'b0;
   localparam logic CSR_ROOT_NODE     = 1'b1;

   // One node table entry.
   typedef struct packed {
      logic             leaf;
      logic [7:0]       symbol;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

endpackage

// ----- design/huffman_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// Huffman bit decoder
// Walks a Huffman code tree held in a node table, one code bit per step.
// ----------------------------------------------------------------------------
// A data byte is decoded most significant bit first, one table lookup per
// step through a single registered read port. A bit that starts on an inner
// node passes through ST_BIT and ST_CHILD (read the parent, then the child);
// a bit whose walk starts on a leaf is done in ST_BIT alone. A new data byte
// is taken only after the last one has left ST_END. Once the stream has
// ended a byte goes from ST_BIT to ST_END without walking, and a byte is
// held up while the result side stalls. Node writes and start requests are
// handled in the idle state. The block takes a new request only when it is
// idle, and configuration writes are taken only then as well. The node
// table has no reset: entries must be written before the walk reaches
// them.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module huffman_bit_decoder (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: node_index[8:0], node_is_leaf[9], node_symbol[17:10],
   // left_index[26:18], right_index[35:27], data_byte[43:36], zero fill.
   input  logic [47:0] req_tdata,
   // Fields from bit 0: kind[1:0].
   input  logic [1:0]  req_tuser,

   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: symbol[7:0].
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // Fields from bit 0: stream_done[0].
   output logic [0:0]  rsp_tuser,

   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_CHILD,
      ST_END
   } state_type;

   // Request field extraction.
   logic [1:0]               req_kind;
   logic [hbd_pkg::IDX_W-1:0] req_node_index;
   hbd_pkg::node_type        req_node;
   logic [7:0]               req_data_byte;
   logic                     req_accept;

   assign req_kind       = req_tuser;
   assign req_node_index = req_tdata[8:0];
   assign req_node.leaf   = req_tdata[9];
   assign req_node.symbol = req_tdata[17:10];
   assign req_node.left   = req_tdata[26:18];
   assign req_node.right  = req_tdata[35:27];
   assign req_data_byte  = req_tdata[43:36];
   assign req_accept     = req_tvalid && req_tready;

   // Registers.
   state_type                      state_ff, state_in;
   logic [31:0]                    total_ff, total_in;
   logic [hbd_pkg::IDX_W-1:0]      root_ff, root_in;
   logic [hbd_pkg::IDX_W-1:0]      current_ff, current_in;
   logic [hbd_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]                     byte_ff, byte_in;
   logic [hbd_pkg::BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [7:0]                     pend_sym_ff, pend_sym_in;
   logic                           pend_done_ff, pend_done_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_sym_ff, rsp_sym_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_done_ff, rsp_done_in;

   // Node table and its registered read port.
   hbd_pkg::node_type              node_mem [hbd_pkg::NODES];
   hbd_pkg::node_type              rd_q_ff;
   logic [hbd_pkg::IDX_W-1:0]      rd_addr;
   logic                           wr_en;

   // Walk helpers.
   logic [hbd_pkg::COUNT_BITS-1:0] count_inc;
   logic                           finished;
   logic                           new_done;
   logic                           out_free;
   logic                           can_emit;
   logic                           bit_val;
   logic [hbd_pkg::IDX_W-1:0]      child;
   logic                           walk_busy;

   localparam logic [hbd_pkg::BIT_W-1:0] FIRST_BIT = hbd_pkg::BIT_W'(hbd_pkg::BYTE_BITS - 1);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_sym_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_done_ff;

   // The stream stops at total_symbols or when the counter saturates.
   assign count_inc = count_ff + 1'b1;
   assign finished  = (64'(count_ff) >= 64'(total_ff)) || (count_ff == '1);
   assign new_done  = (64'(count_inc) >= 64'(total_ff)) || (count_inc == '1);

   // A new symbol may enter the pending slot once the older one can move on.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !pend_valid_ff || out_free;

   assign bit_val = byte_ff[bit_cnt_ff];
   assign child   = bit_val ? rd_q_ff.right : rd_q_ff.left;

   // The sequencer is stepping through the bits of a byte.
   assign walk_busy = (state_ff == ST_BIT) || (state_ff == ST_CHILD);

   // Node writes land while idle; indices past the table are dropped.
   assign wr_en = req_accept && (req_kind == hbd_pkg::KIND_NODE) &&
                  (32'(req_node_index) < 32'(hbd_pkg::NODES));

   // Table write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[hbd_pkg::NODE_BITS'(req_node_index)] <= req_node;
      end
      if (32'(rd_addr) < 32'(hbd_pkg::NODES)) begin
         rd_q_ff <= node_mem[hbd_pkg::NODE_BITS'(rd_addr)];
      end else begin
         rd_q_ff <= '0;
      end
   end

   // Sequencer: one table lookup per step of the walk.
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      root_in       = root_ff;
      current_in    = current_ff;
      count_in      = count_ff;
      byte_in       = byte_ff;
      bit_cnt_in    = bit_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rd_addr       = current_ff;

      case (state_ff)
         ST_IDLE: begin
            // Configuration writes.
            if (csr_valid && csr_ready) begin
               case (csr_index)
                  hbd_pkg::CSR_TOTAL_SYMBOLS: total_in = csr_data;
                  hbd_pkg::CSR_ROOT_NODE:     root_in  = csr_data[hbd_pkg::IDX_W-1:0];
                  default: ;
               endcase
            end
            if (req_accept) begin
               case (req_kind)
                  hbd_pkg::KIND_DATA: begin
                     byte_in    = req_data_byte;
                     bit_cnt_in = FIRST_BIT;
                     state_in   = ST_BIT;
                  end
                  hbd_pkg::KIND_START: begin
                     current_in = root_ff;
                     count_in   = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_BIT: begin
            // The read data holds the entry of the current node.
            if (finished) begin
               state_in = ST_END;
            end else if (rd_q_ff.leaf) begin
               if (can_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                     rsp_done_in  = pend_done_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = rd_q_ff.symbol;
                  pend_done_in  = new_done;
                  count_in      = count_inc;
                  current_in    = root_ff;
                  rd_addr       = root_ff;
                  if (bit_cnt_ff == '0) begin
                     state_in = ST_END;
                  end else begin
                     bit_cnt_in = bit_cnt_ff - 1'b1;
                  end
               end
            end else begin
               current_in = child;
               rd_addr    = child;
               state_in   = ST_CHILD;
            end
         end

         ST_CHILD: begin
            // The read data holds the entry of the child just stepped to.
            if (rd_q_ff.leaf) begin
               if (can_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                     rsp_done_in  = pend_done_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = rd_q_ff.symbol;
                  pend_done_in  = new_done;
                  count_in      = count_inc;
                  current_in    = root_ff;
                  rd_addr       = root_ff;
                  if (bit_cnt_ff == '0) begin
                     state_in = ST_END;
                  end else begin
                     bit_cnt_in = bit_cnt_ff - 1'b1;
                     state_in   = ST_BIT;
                  end
               end
            end else if (bit_cnt_ff == '0) begin
               state_in = ST_END;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
               state_in   = ST_BIT;
            end
         end

         ST_END: begin
            // Hand over the final symbol of this byte, marked as last.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               rsp_done_in   = pend_done_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         root_ff       <= '0;
         current_ff    <= '0;
         count_ff      <= '0;
         bit_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         root_ff       <= root_in;
         current_ff    <= current_in;
         count_ff      <= count_in;
         bit_cnt_ff    <= bit_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Assertions.
   `ASSERT_IMPLY(a_idle_no_pending, clock, reset, req_tready, !pend_valid_ff, "left pending")
   `ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast, "not last")
   `ASSERT_IMPLY(a_child_after_bit, clock, reset, state_ff == ST_CHILD, $past(walk_busy), "no walk")
   `ASSERT_IMPLY(a_stop_at_end, clock, reset, finished && walk_busy, count_in == count_ff, "late")

endmodule
